### rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned Rounds = 64;
   localparam int unsigned DigestWords = 8;
   localparam logic [7:0] PadMark = 8'h80;
   localparam logic [5:0] LenFieldAt = 6'd56;
   localparam int unsigned QueueDepth = 4;

   typedef logic [31:0] word_type;

   // One entry of the queue between the front and the back part.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_present;
      logic       message_end;
   } job_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       byte_present;
      logic       message_end;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   function automatic word_type round_const(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### rtl/core/sha256_stream_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for the request and response items.
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic                         valid;
   logic                         ready;
   sha256_pkg::req_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sha256_rsp_if;
   logic                         valid;
   logic                         ready;
   sha256_pkg::rsp_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
//   channel   direction   carries
//   req       in          byte_value, byte_present, message_end
//   rsp       out         digest_word, word_index, last_word
//
// An accepted item is registered in the queue; the back part takes one
// byte a cycle from it while idle. The 64th byte of a block starts a
// compression: 64 rounds, then a step that folds into the chaining words.
// A message end pads one byte a cycle up to the block end, with one or two
// compressions, then offers eight response items, one a cycle while ready.
// Synchronous reset restores the initial hash and empties the queue.
// The four-entry queue accepts items while the back part is busy, until full.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
   input  logic          clock,
   input  logic          reset,
   sha256_req_if.sink    req,
   sha256_rsp_if.source  rsp
);

   sha256_pkg::job_type job;
   logic                job_valid;
   logic                job_take;

   sha256_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .job       (job),
      .job_valid (job_valid),
      .job_take  (job_take)
   );

   sha256_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_take  (job_take),
      .rsp       (rsp)
   );

endmodule

### rtl/core/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front part
// Accepts items, drops empty ones, and queues the rest for the back part.
// ----------------------------------------------------------------------------
module sha256_front (
   input  logic                clock,
   input  logic                reset,
   sha256_req_if.sink          req,
   output sha256_pkg::job_type job,
   output logic                job_valid,
   input  logic                job_take
);

   localparam int unsigned PtrBits = $clog2(sha256_pkg::QueueDepth);

   sha256_pkg::job_type     queue_ff [sha256_pkg::QueueDepth];
   logic [PtrBits-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]        count_ff, count_in;
   logic                    push;
   logic                    pop;

   assign req.ready = (count_ff != (PtrBits+1)'(sha256_pkg::QueueDepth));
   assign push = req.valid && req.ready &&
                 (req.payload.byte_present || req.payload.message_end);
   assign pop = job_take && job_valid;
   assign job_valid = (count_ff != '0);
   assign job = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{byte_value: req.payload.byte_value,
                                  byte_present: req.payload.byte_present,
                                  message_end: req.payload.message_end};
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrBits+1)'(sha256_pkg::QueueDepth))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push not counted");

endmodule

### rtl/core/sha256_back.sv
// ----------------------------------------------------------------------------
// SHA-256 back part
// Shifts bytes into the block, pads, runs one compression round per cycle,
// and emits the digest words.
// ----------------------------------------------------------------------------
module sha256_back (
   input  logic                clock,
   input  logic                reset,
   input  sha256_pkg::job_type job,
   input  logic                job_valid,
   output logic                job_take,
   sha256_rsp_if.source        rsp
);

   typedef enum logic [2:0] {
      IDLE, PAD, ROUND, ADD, EMIT
   } state_type;

   state_type              state_ff;
   sha256_pkg::word_type   w_ff [16];
   logic [5:0]             fill_ff;
   logic [63:0]            total_ff;
   sha256_pkg::word_type   chain_ff [8];
   sha256_pkg::word_type   v_ff [8];
   logic [5:0]             round_ff;
   logic                   final_ff;
   logic                   mark_done_ff;
   logic                   zero_rest_ff;
   logic                   len_done_ff;
   logic [2:0]             out_idx_ff;
   logic                   out_valid_ff;

   sha256_pkg::word_type   w_new, t1, t2, s0, s1, big0, big1, ch, maj;
   sha256_pkg::word_type   w_shift [16];
   sha256_pkg::word_type   w_round [16];
   logic [63:0]            bits;
   logic [7:0]             pad_byte;
   logic [7:0]             shift_byte;

   assign bits = {total_ff[60:0], 3'b000};
   assign job_take = (state_ff == IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.payload.digest_word = chain_ff[out_idx_ff];
   assign rsp.payload.word_index = out_idx_ff;
   assign rsp.payload.last_word = (out_idx_ff == 3'd7);

   always_comb begin
      pad_byte = 8'h00;
      if (!mark_done_ff) begin
         pad_byte = sha256_pkg::PadMark;
      end else if (!zero_rest_ff && fill_ff >= sha256_pkg::LenFieldAt) begin
         pad_byte = bits[8 * (3'd7 - fill_ff[2:0]) +: 8];
      end
      shift_byte = (state_ff == PAD) ? pad_byte : job.byte_value;
      for (int i = 0; i < 15; i++) begin
         w_shift[i] = {w_ff[i][23:0], w_ff[i+1][31:24]};
      end
      w_shift[15] = {w_ff[15][23:0], shift_byte};

      s0 = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
           ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      for (int i = 0; i < 15; i++) begin
         w_round[i] = w_ff[i+1];
      end
      w_round[15] = w_new;

      big1 = sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
             ^ sha256_pkg::rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + big1 + ch + sha256_pkg::round_const(round_ff) + w_ff[0];
      big0 = sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
             ^ sha256_pkg::rotr(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = big0 + maj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         fill_ff <= '0;
         total_ff <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff <= '0;
         final_ff <= 1'b0;
         mark_done_ff <= 1'b0;
         zero_rest_ff <= 1'b0;
         len_done_ff <= 1'b0;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha256_pkg::init_hash(3'(i));
      end else begin
         case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  final_ff <= job.message_end;
                  if (job.byte_present) begin
                     w_ff <= w_shift;
                     total_ff <= total_ff + 64'd1;
                     fill_ff <= fill_ff + 6'd1;
                     if (fill_ff == 6'd63) begin
                        state_ff <= ROUND;
                        round_ff <= '0;
                        v_ff <= chain_ff;
                     end else if (job.message_end) begin
                        state_ff <= PAD;
                     end
                  end else if (job.message_end) begin
                     state_ff <= PAD;
                  end
               end
            end
            PAD: begin
               // Pad mark, zeros, then the length once the mark fits.
               w_ff <= w_shift;
               fill_ff <= fill_ff + 6'd1;
               mark_done_ff <= 1'b1;
               if (fill_ff == 6'd63) begin
                  zero_rest_ff <= 1'b0;
                  len_done_ff <= mark_done_ff && !zero_rest_ff;
                  state_ff <= ROUND;
                  round_ff <= '0;
                  v_ff <= chain_ff;
               end else if (!mark_done_ff) begin
                  zero_rest_ff <= (fill_ff >= sha256_pkg::LenFieldAt);
               end
            end
            ROUND: begin
               w_ff <= w_round;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= ADD;
            end
            ADD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
               if (final_ff && len_done_ff) begin
                  out_valid_ff <= 1'b1;
                  out_idx_ff <= '0;
                  state_ff <= EMIT;
               end else if (final_ff) begin
                  state_ff <= PAD;
               end else begin
                  state_ff <= IDLE;
               end
            end
            EMIT: begin
               if (rsp.ready) begin
                  out_idx_ff <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) begin
                     out_valid_ff <= 1'b0;
                     state_ff <= IDLE;
                     total_ff <= '0;
                     final_ff <= 1'b0;
                     mark_done_ff <= 1'b0;
                     len_done_ff <= 1'b0;
                     for (int i = 0; i < 8; i++)
                        chain_ff[i] <= sha256_pkg::init_hash(3'(i));
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> state_ff == EMIT)
      else $error("digest shown outside emit");
   assert property (@(posedge clock) disable iff (reset)
      job_take |-> !out_valid_ff)
      else $error("new item taken while digest pending");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ROUND && round_ff == 6'd63) |=> state_ff == ADD)
      else $error("round count lost");

endmodule
